### rtl/core/eh_pointer_encoding_decoder_top_defines.svh
// ----------------------------------------------------------------------------
// EH pointer decoder assertion macros
// Shared concurrent assertion forms for the pointer decoder.
// ----------------------------------------------------------------------------
`ifndef EH_POINTER_ENCODING_DECODER_TOP_DEFINES_SVH
`define EH_POINTER_ENCODING_DECODER_TOP_DEFINES_SVH

// Checks that a condition implies a property in the same cycle.
`define EHP_ASSERT_NOW(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("EH pointer decoder assertion failed");

// Checks that a condition implies a property in the next cycle.
`define EHP_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("EH pointer decoder assertion failed");

`endif

### rtl/core/ehp_pkg.sv
// ----------------------------------------------------------------------------
// EH pointer decoder package
// Encoding formats, relative modes, status codes and sizes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ehp_pkg;

  localparam int POINTER_BYTES_DEFAULT = 8;

  localparam int VALUE_W  = 64;
  localparam int COUNT_W  = 4;
  localparam int SHIFT_W  = 7;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 72;
  localparam int OUT_USER_W = 4;

  localparam logic [COUNT_W-1:0] LEB_MAX_BYTES = 4'd10;

  localparam logic [3:0] FMT_ABSPTR = 4'h0;
  localparam logic [3:0] FMT_ULEB   = 4'h1;
  localparam logic [3:0] FMT_UDATA2 = 4'h2;
  localparam logic [3:0] FMT_UDATA4 = 4'h3;
  localparam logic [3:0] FMT_UDATA8 = 4'h4;
  localparam logic [3:0] FMT_SLEB   = 4'h9;
  localparam logic [3:0] FMT_SDATA2 = 4'hA;
  localparam logic [3:0] FMT_SDATA4 = 4'hB;
  localparam logic [3:0] FMT_SDATA8 = 4'hC;

  localparam logic [2:0] REL_NONE  = 3'h0;
  localparam logic [2:0] REL_PC    = 3'h1;
  localparam logic [2:0] REL_TEXT  = 3'h2;
  localparam logic [2:0] REL_DATA  = 3'h3;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_FORMAT = 3'd1,
    ST_BAD_REL    = 3'd2,
    ST_ZERO_BASE  = 3'd3,
    ST_LEB_OVF    = 3'd4
  } status_e;

endpackage

`default_nettype wire

### rtl/core/eh_pointer_encoding_decoder_top.sv
// A result word enters the result register once the last byte in the input
// register is processed. Throughput: one byte per cycle while the output is
// not stalled; one more byte can enter the input register while a finished
// result waits to be taken. The per-byte path is one shift-and-merge into the
// accumulator plus one 64-bit base add. Asynchronous active-low reset clears
// control state and the data base register.
// ----------------------------------------------------------------------------
// EH pointer decoder top level
// Decodes byte-serial DWARF EH encoded pointers into values with status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "eh_pointer_encoding_decoder_top_defines.svh"

module eh_pointer_encoding_decoder_top #(
  parameter int POINTER_BYTES = ehp_pkg::POINTER_BYTES_DEFAULT
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [ehp_pkg::VALUE_W-1:0]    cfg_data_i,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // data_byte [7:0], encoding [15:8], item_addr [79:16]
  input  wire logic [ehp_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // first_byte [0]
  input  wire logic                           s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // value [63:0], byte_count [67:64], zero [71:68]
  output logic [ehp_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // needs_indirect [0], status [3:1]
  output logic [ehp_pkg::OUT_USER_W-1:0]      m_axis_tuser
);
  import ehp_pkg::*;

  localparam int PtrBits = POINTER_BYTES * 8;
  localparam logic [VALUE_W-1:0] PtrMask = {VALUE_W{1'b1}} >> (VALUE_W - PtrBits);
  localparam logic [COUNT_W-1:0] NativeLen = COUNT_W'(POINTER_BYTES);

  logic [VALUE_W-1:0] base_q;

  logic               in_valid_q;
  logic [7:0]         in_byte_q;
  logic               in_first_q;
  logic [7:0]         in_enc_q;
  logic [VALUE_W-1:0] in_addr_q;

  logic [VALUE_W-1:0] acc_q, acc_d;
  logic [SHIFT_W-1:0] shift_q, shift_d;
  logic [COUNT_W-1:0] taken_q, taken_d;
  logic [7:0]         enc_q;
  logic [VALUE_W-1:0] addr_q;
  logic               ovf_q, ovf_d;

  logic               out_valid_q, out_valid_d;
  logic [VALUE_W-1:0] out_value_q, out_value_d;
  logic [COUNT_W-1:0] out_count_q, out_count_d;
  logic               out_ind_q, out_ind_d;
  status_e            out_status_q, out_status_d;

  logic               out_free;
  logic               work;
  logic               active;
  logic [7:0]         cur_enc;
  logic [VALUE_W-1:0] cur_addr;
  logic [VALUE_W-1:0] acc_b;
  logic [SHIFT_W-1:0] shift_b;
  logic [COUNT_W-1:0] taken_b;
  logic               ovf_b;
  logic [COUNT_W-1:0] fix_len;
  logic               is_leb;
  logic               bad_fmt;
  logic               bad_now;
  logic               done;
  logic [VALUE_W+6:0] leb_wide;
  logic [VALUE_W-1:0] rel_base;
  logic [VALUE_W-1:0] sum;
  status_e            status;
  logic               res_fire;

  assign cfg_ready_o   = 1'b1;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || out_free;
  assign work          = in_valid_q && out_free;

  assign cur_enc  = in_first_q ? in_enc_q : enc_q;
  assign cur_addr = in_first_q ? in_addr_q : addr_q;
  assign acc_b    = in_first_q ? '0 : acc_q;
  assign shift_b  = in_first_q ? '0 : shift_q;
  assign taken_b  = in_first_q ? '0 : taken_q;
  assign ovf_b    = in_first_q ? 1'b0 : ovf_q;
  assign active   = in_first_q || (taken_q != '0);
  assign bad_now  = in_first_q && bad_fmt;

  always_comb begin
    fix_len = '0;
    is_leb  = 1'b0;
    bad_fmt = 1'b0;
    case (cur_enc[3:0])
      FMT_ABSPTR: begin
        fix_len = NativeLen;
      end
      FMT_ULEB, FMT_SLEB: begin
        is_leb = 1'b1;
      end
      FMT_UDATA2, FMT_SDATA2: begin
        fix_len = 4'd2;
      end
      FMT_UDATA4, FMT_SDATA4: begin
        fix_len = 4'd4;
      end
      FMT_UDATA8, FMT_SDATA8: begin
        fix_len = 4'd8;
      end
      default: begin
        bad_fmt = 1'b1;
      end
    endcase
  end

  always_comb begin
    acc_d    = acc_b;
    shift_d  = shift_b;
    taken_d  = taken_b + 4'd1;
    ovf_d    = ovf_b;
    done     = 1'b0;
    leb_wide = {{VALUE_W{1'b0}}, in_byte_q[6:0]} << shift_b[5:0];
    if (is_leb) begin
      if (shift_b[6] || (|leb_wide[VALUE_W+6:VALUE_W])) begin
        ovf_d = 1'b1;
      end else begin
        acc_d = acc_b | leb_wide[VALUE_W-1:0];
      end
      shift_d = shift_b + 7'd7;
      if (!in_byte_q[7]) begin
        done = 1'b1;
        if (cur_enc[3] && in_byte_q[6] && !ovf_d && !shift_d[6]) begin
          acc_d = acc_d | ({VALUE_W{1'b1}} << shift_d[5:0]);
        end
      end else if (taken_d >= LEB_MAX_BYTES) begin
        done  = 1'b1;
        ovf_d = 1'b1;
      end
    end else begin
      if (!shift_b[6]) begin
        acc_d = acc_b | ({56'd0, in_byte_q} << shift_b[5:0]);
      end
      shift_d = shift_b + 7'd8;
      if (taken_d >= fix_len) begin
        done = 1'b1;
        if (cur_enc[3] && (fix_len == 4'd2) && acc_d[15]) begin
          acc_d[VALUE_W-1:16] = '1;
        end
        if (cur_enc[3] && (fix_len == 4'd4) && acc_d[31]) begin
          acc_d[VALUE_W-1:32] = '1;
        end
      end
    end
  end

  always_comb begin
    rel_base = '0;
    status   = ST_OK;
    case (cur_enc[6:4])
      REL_NONE: begin
        rel_base = '0;
      end
      REL_PC: begin
        rel_base = cur_addr;
      end
      REL_DATA: begin
        rel_base = base_q;
        if (base_q == '0) begin
          status = ST_ZERO_BASE;
        end
      end
      default: begin
        status = ST_BAD_REL;
      end
    endcase
    if (ovf_d) begin
      status = ST_LEB_OVF;
    end
    if (bad_now) begin
      status = ST_BAD_FORMAT;
    end
    sum = acc_d + rel_base;
  end

  assign res_fire = work && active && (bad_now || done);

  always_comb begin
    out_valid_d  = out_valid_q;
    out_value_d  = out_value_q;
    out_count_d  = out_count_q;
    out_ind_d    = out_ind_q;
    out_status_d = out_status_q;
    if (out_free) begin
      out_valid_d = res_fire;
    end
    if (res_fire) begin
      out_status_d = status;
      out_count_d  = bad_now ? 4'd1 : taken_d;
      out_value_d  = (status == ST_OK) ? (sum & PtrMask) : '0;
      out_ind_d    = (status == ST_OK) ? cur_enc[7] : 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else if (cfg_valid_i) begin
      base_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q  <= s_axis_tdata[7:0];
      in_enc_q   <= s_axis_tdata[15:8];
      in_addr_q  <= s_axis_tdata[79:16];
      in_first_q <= s_axis_tuser;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      shift_q <= '0;
      taken_q <= '0;
      enc_q   <= '0;
      addr_q  <= '0;
      ovf_q   <= 1'b0;
    end else if (work && active) begin
      if (in_first_q) begin
        enc_q  <= in_enc_q;
        addr_q <= in_addr_q;
      end
      if (bad_now || done) begin
        acc_q   <= '0;
        shift_q <= '0;
        taken_q <= '0;
        ovf_q   <= 1'b0;
      end else begin
        acc_q   <= acc_d;
        shift_q <= shift_d;
        taken_q <= taken_d;
        ovf_q   <= ovf_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q  <= out_value_d;
    out_count_q  <= out_count_d;
    out_ind_q    <= out_ind_d;
    out_status_q <= out_status_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_count_q, out_value_q};
  assign m_axis_tuser  = {out_status_q, out_ind_q};

  `EHP_ASSERT_NEXT(a_bad_fmt_result, clk_i, rst_ni, work && bad_now,
      out_valid_q && (out_status_q == ST_BAD_FORMAT) && (out_count_q == 4'd1))
  `EHP_ASSERT_NOW(a_error_clears_value, clk_i, rst_ni,
      out_valid_q && (out_status_q != ST_OK), (out_value_q == '0) && !out_ind_q)
  `EHP_ASSERT_NOW(a_count_range, clk_i, rst_ni, out_valid_q,
      (out_count_q != '0) && (out_count_q <= LEB_MAX_BYTES))
  `EHP_ASSERT_NOW(a_partial_bound, clk_i, rst_ni, 1'b1, taken_q < LEB_MAX_BYTES)

endmodule

`default_nettype wire
